// File: src/ttt_pkg.sv
// Shared constants, widths and tables for the two-angle triangulation tracker.
// No dependencies; the RTL files and the checker refer to this package by scoped names.
package ttt_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 8;

    // CORDIC datapath widths
    localparam int CW    = 38;
    localparam int ZW    = 34;
    localparam int CNT_W = $clog2(CORDIC_STEPS);

    // Divider widths (dividend, divisor)
    localparam int DIV_NW  = 66;
    localparam int DIV_DW  = 34;
    localparam int DIV_CW  = $clog2(DIV_NW);

    // Multiplier widths
    localparam int MUL_AW = 64;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Square root widths
    localparam int SQ_W  = 64;
    localparam int SQ_KW = 5;

    localparam logic [14:0] ANGLE_MAX    = 15'd23039;
    localparam logic [22:0] DEG_TO_RAD_Q = 23'd4685083;
    localparam logic [31:0] RAD_TO_DEG_Q = 32'd15019745;
    localparam logic [15:0] HEADING_MAX  = 16'd23040;
    localparam logic [23:0] BASE_RESET   = 24'd128000;

    // atan(2^-i) in Q30 radians
    function automatic logic [ZW-1:0] atan_step(input logic [5:0] i);
        logic [ZW-1:0] v;
        v = '0;
        unique case (i)
            6'd0: v = ZW'(843314857);
            6'd1: v = ZW'(497837829);
            6'd2: v = ZW'(263043837);
            6'd3: v = ZW'(133525159);
            6'd4: v = ZW'(67021687);
            6'd5: v = ZW'(33543516);
            6'd6: v = ZW'(16775851);
            6'd7: v = ZW'(8388437);
            6'd8: v = ZW'(4194283);
            6'd9: v = ZW'(2097149);
            default:
            begin
                if (i <= 6'd30)
                    v = ZW'(1) << (6'd30 - i);
            end
        endcase
        return v;
    endfunction

endpackage

// File: src/ttt_cordic.sv
// Iterative CORDIC, rotation or vectoring mode, one micro-rotation a cycle.
// Depends on ttt_pkg.
module ttt_cordic
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             vect,
    input  logic signed [ttt_pkg::CW-1:0]    x_in,
    input  logic signed [ttt_pkg::CW-1:0]    y_in,
    input  logic signed [ttt_pkg::ZW-1:0]    z_in,
    output logic                             done,
    output logic signed [ttt_pkg::CW-1:0]    x_out,
    output logic signed [ttt_pkg::CW-1:0]    y_out,
    output logic signed [ttt_pkg::ZW-1:0]    z_out
);

    logic                            busy_reg;
    logic                            done_reg;
    logic                            vect_reg;
    logic [ttt_pkg::CNT_W-1:0]       cnt_reg;
    logic signed [ttt_pkg::CW-1:0]   x_reg;
    logic signed [ttt_pkg::CW-1:0]   y_reg;
    logic signed [ttt_pkg::ZW-1:0]   z_reg;

    logic signed [ttt_pkg::CW-1:0]   xs;
    logic signed [ttt_pkg::CW-1:0]   ys;
    logic signed [ttt_pkg::ZW-1:0]   ang;
    logic                            d_pos;

    always_comb
    begin
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
        ang   = signed'(ttt_pkg::atan_step(6'(cnt_reg)));
        // vectoring drives y to zero, rotation drives z to zero
        d_pos = vect_reg ? (y_reg[ttt_pkg::CW-1] || (y_reg == '0))
                         : !z_reg[ttt_pkg::ZW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == ttt_pkg::CNT_W'(ttt_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vect_reg <= vect;
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
        end
        else if (busy_reg)
        begin
            if (d_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: src/ttt_div.sv
// Restoring bit-serial unsigned divider, one quotient bit a cycle.
// Depends on ttt_pkg.
module ttt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ttt_pkg::DIV_NW-1:0]    dividend,
    input  logic [ttt_pkg::DIV_DW-1:0]    divisor,
    output logic                          done,
    output logic [ttt_pkg::DIV_NW-1:0]    quo,
    output logic [ttt_pkg::DIV_DW-1:0]    rem
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [ttt_pkg::DIV_CW-1:0]     cnt_reg;
    logic [ttt_pkg::DIV_NW-1:0]     n_reg;
    logic [ttt_pkg::DIV_DW-1:0]     r_reg;
    logic [ttt_pkg::DIV_DW-1:0]     d_reg;

    logic [ttt_pkg::DIV_DW:0]       trial;
    logic [ttt_pkg::DIV_DW:0]       diff;
    logic                           ge;

    always_comb
    begin
        trial = {r_reg, n_reg[ttt_pkg::DIV_NW-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == ttt_pkg::DIV_CW'(ttt_pkg::DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[ttt_pkg::DIV_NW-2:0], ge};
            r_reg <= ge ? diff[ttt_pkg::DIV_DW-1:0] : trial[ttt_pkg::DIV_DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = n_reg;
    assign rem  = r_reg;

endmodule

// File: src/ttt_mul.sv
// Unsigned 64 x 32 multiplier built from two registered 32 x 32 partial products.
// Depends on ttt_pkg.
module ttt_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ttt_pkg::MUL_AW-1:0]    a,
    input  logic [ttt_pkg::MUL_BW-1:0]    b,
    output logic                          done,
    output logic [ttt_pkg::MUL_PW-1:0]    prod
);

    localparam int HW = ttt_pkg::MUL_AW / 2;

    logic                           busy_reg;
    logic                           done_reg;
    logic [1:0]                     phase_reg;
    logic [ttt_pkg::MUL_AW-1:0]     a_reg;
    logic [ttt_pkg::MUL_BW-1:0]     b_reg;
    logic [HW+ttt_pkg::MUL_BW-1:0]  p0_reg;
    logic [HW+ttt_pkg::MUL_BW-1:0]  p1_reg;
    logic [ttt_pkg::MUL_PW-1:0]     prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                2'd0:    p0_reg <= a_reg[HW-1:0] * b_reg;
                2'd1:    p1_reg <= a_reg[ttt_pkg::MUL_AW-1:HW] * b_reg;
                default: prod_reg <= {p1_reg, {HW{1'b0}}}
                                     + ttt_pkg::MUL_PW'(p0_reg);
            endcase
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: src/ttt_sqrt.sv
// Bit-pair integer square root of a 64-bit value, one result bit a cycle.
// Depends on ttt_pkg.
module ttt_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ttt_pkg::SQ_W-1:0]    v,
    output logic                        done,
    output logic [ttt_pkg::SQ_W/2-1:0]  root
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [ttt_pkg::SQ_KW-1:0]    k_reg;
    logic [ttt_pkg::SQ_W-1:0]     v_reg;
    logic [ttt_pkg::SQ_W-1:0]     res_reg;

    logic [ttt_pkg::SQ_W-1:0]     bitv;
    logic [ttt_pkg::SQ_W-1:0]     sum;

    always_comb
    begin
        bitv = ttt_pkg::SQ_W'(1) << {k_reg, 1'b0};
        sum  = res_reg + bitv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '1;
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                k_reg <= k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= v;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= sum)
            begin
                v_reg   <= v_reg - sum;
                res_reg <= (res_reg >> 1) + bitv;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ttt_pkg::SQ_W/2-1:0];

endmodule

// File: src/two_angle_triangulation_tracker.sv
// Each word runs the shared units in turn: the divider (up to four runs), the CORDIC (up to
// three runs), the root and the multiplies. Equal tangents skip the position solve, and a
// first sample, with no previous position, skips speed and heading. Input is taken only
// while idle, and a result word held by m_tready stalls the sequencer at hand-off. Reset
// (rst_n, async low): sequencer idle, no output word, no previous position, baseline back
// to 500 m. Depends on ttt_pkg and the cordic, div, mul, sqrt units.
module two_angle_triangulation_tracker
(
    input  logic           clk,
    input  logic           rst_n,
    // input words
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,   // angle_near[14:0], angle_far[29:15], zero pad
    // result words
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [111:0]   m_tdata,   // pos_x[31:0], pos_y[63:32], speed[95:64],
                                      // heading[111:96]
    output logic [1:0]     m_tuser,   // motion_valid[0], geometry_error[1]
    // baseline register
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [23:0]    cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE, S_TA_GO, S_TA_W, S_TAD_GO, S_TAD_W, S_TB_GO, S_TB_W, S_TBD_GO, S_TBD_W,
        S_DIF, S_P_GO, S_P_W, S_Q_GO, S_Q_W, S_QT_GO, S_QT_W, S_RT_GO, S_RT_W,
        S_RTD_GO, S_RTD_W, S_SAT, S_MOT, S_SX_GO, S_SX_W, S_SY_GO, S_SY_W,
        S_SQ_GO, S_SQ_W, S_HD, S_HV_GO, S_HV_W, S_HM_GO, S_HM_W, S_OUT
    } state_t;

    state_t              state_reg;

    logic [23:0]         base_reg;
    logic [14:0]         an_reg;
    logic [14:0]         af_reg;
    logic [31:0]         ta_reg;
    logic [31:0]         tb_reg;
    logic                err_reg;
    logic [31:0]         ad_reg;
    logic                neg_reg;
    logic [55:0]         p_reg;
    logic [55:0]         q_reg;
    logic [31:0]         r_reg;
    logic [63:0]         qt_reg;
    logic [63:0]         rt_reg;
    logic [63:0]         my_reg;
    logic signed [31:0]  px_reg;
    logic signed [31:0]  py_reg;
    logic signed [32:0]  dx_reg;
    logic signed [32:0]  dy_reg;
    logic [63:0]         sx_reg;
    logic [63:0]         sq_reg;
    logic [31:0]         spd_reg;
    logic signed [15:0]  hd_reg;
    logic [33:0]         hz_reg;
    logic signed [31:0]  last_x_reg;
    logic signed [31:0]  last_y_reg;
    logic                have_last_reg;

    logic                out_valid_reg;
    logic [111:0]        out_data_reg;
    logic [1:0]          out_user_reg;

    // shared unit hookup
    logic                cor_start, cor_vect, cor_done;
    logic signed [ttt_pkg::CW-1:0] cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [ttt_pkg::ZW-1:0] cor_z_in, cor_z;
    logic                div_start, div_done;
    logic [ttt_pkg::DIV_NW-1:0] div_n, div_q;
    logic [ttt_pkg::DIV_DW-1:0] div_d, div_r;
    logic                mul_start, mul_done;
    logic [ttt_pkg::MUL_AW-1:0] mul_a;
    logic [ttt_pkg::MUL_BW-1:0] mul_b;
    logic [ttt_pkg::MUL_PW-1:0] mul_p;
    logic                sq_start, sq_done;
    logic [31:0]         sq_root;

    // helpers
    logic [37:0]         zprod;
    logic [14:0]         ang_sel;
    logic [ttt_pkg::DIV_DW-1:0] tan_x;
    logic [ttt_pkg::CW-1:0]     tan_y;
    logic signed [32:0]  dtan;
    logic [32:0]         ux;
    logic [32:0]         uy;
    logic [64:0]         ssum;
    logic [63:0]         hsum;
    logic [15:0]         hmag;
    logic [32:0]         sat_x;
    logic [32:0]         sat_y;
    logic                out_take;

    // magnitude to int32 with the error flag on top
    function automatic logic [32:0] sat32(input logic [63:0] mag, input logic neg);
        logic [32:0] o;
        if (!neg)
        begin
            if (mag > 64'h7FFF_FFFF)
                o = {1'b1, 32'h7FFF_FFFF};
            else
                o = {1'b0, mag[31:0]};
        end
        else
        begin
            if (mag > 64'h8000_0000)
                o = {1'b1, 32'h8000_0000};
            else
                o = {1'b0, 32'(-mag)};
        end
        return o;
    endfunction

    always_comb
    begin
        // degrees*256 to Q30 radians
        ang_sel = (state_reg == S_TB_GO) ? af_reg : an_reg;
        zprod   = ang_sel * ttt_pkg::DEG_TO_RAD_Q + 38'd32;

        // cosine clamped to one unit, sine clamped at zero
        if (cor_x < ttt_pkg::CW'(signed'(2'sd1)))
            tan_x = ttt_pkg::DIV_DW'(1);
        else
            tan_x = cor_x[ttt_pkg::DIV_DW-1:0];
        tan_y = cor_y[ttt_pkg::CW-1] ? '0 : cor_y;

        dtan  = signed'({1'b0, tb_reg}) - signed'({1'b0, ta_reg});
        ux    = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        uy    = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        ssum  = {1'b0, sx_reg} + {1'b0, mul_p[63:0]};
        hsum  = mul_p[63:0] + (64'd1 << 39);
        hmag  = (hsum[63:40] > 24'(ttt_pkg::HEADING_MAX)) ? ttt_pkg::HEADING_MAX
                                                          : hsum[55:40];
        sat_x = sat32(64'(q_reg), neg_reg);
        sat_y = sat32(my_reg, neg_reg);

        // hand-off into the output register once it is free or being drained
        out_take = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
    end

    // unit operand selection
    always_comb
    begin
        cor_start = (state_reg == S_TA_GO) || (state_reg == S_TB_GO)
                    || (state_reg == S_HV_GO);
        cor_vect  = (state_reg == S_HV_GO);
        cor_x_in  = cor_vect ? signed'(ttt_pkg::CW'(ux)) : ttt_pkg::CW'(64'd1 << 30);
        cor_y_in  = cor_vect ? signed'(ttt_pkg::CW'(uy)) : '0;
        cor_z_in  = cor_vect ? '0 : signed'(ttt_pkg::ZW'(zprod[37:6]));

        div_start = (state_reg == S_TAD_GO) || (state_reg == S_TBD_GO)
                    || (state_reg == S_Q_GO) || (state_reg == S_RTD_GO);
        unique case (state_reg)
            S_TAD_GO, S_TBD_GO:
            begin
                div_n = (ttt_pkg::DIV_NW'(tan_y) << ttt_pkg::FRAC_BITS)
                        + ttt_pkg::DIV_NW'(tan_x >> 1);
                div_d = tan_x;
            end
            S_Q_GO:
            begin
                div_n = ttt_pkg::DIV_NW'(p_reg);
                div_d = ttt_pkg::DIV_DW'(ad_reg);
            end
            default:
            begin
                div_n = ttt_pkg::DIV_NW'(rt_reg);
                div_d = ttt_pkg::DIV_DW'(ad_reg);
            end
        endcase

        mul_start = (state_reg == S_P_GO) || (state_reg == S_QT_GO)
                    || (state_reg == S_RT_GO) || (state_reg == S_SX_GO)
                    || (state_reg == S_SY_GO) || (state_reg == S_HM_GO);
        unique case (state_reg)
            S_P_GO:
            begin
                mul_a = 64'(base_reg);
                mul_b = tb_reg;
            end
            S_QT_GO:
            begin
                mul_a = 64'(q_reg);
                mul_b = ta_reg;
            end
            S_RT_GO:
            begin
                mul_a = 64'(r_reg);
                mul_b = ta_reg;
            end
            S_SX_GO:
            begin
                mul_a = 64'(ux);
                mul_b = ux[31:0];
            end
            S_SY_GO:
            begin
                mul_a = 64'(uy);
                mul_b = uy[31:0];
            end
            default:
            begin
                mul_a = 64'(hz_reg);
                mul_b = ttt_pkg::RAD_TO_DEG_Q;
            end
        endcase

        sq_start = (state_reg == S_SQ_GO);
    end

    ttt_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .vect  (cor_vect),
        .x_in  (cor_x_in),
        .y_in  (cor_y_in),
        .z_in  (cor_z_in),
        .done  (cor_done),
        .x_out (cor_x),
        .y_out (cor_y),
        .z_out (cor_z)
    );

    ttt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quo      (div_q),
        .rem      (div_r)
    );

    ttt_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    ttt_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .v     (sq_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // control: sequencer, output word flag, stored position and baseline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            have_last_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            base_reg      <= ttt_pkg::BASE_RESET;
        end
        else
        begin
            if (cfg_valid)
                base_reg <= cfg_data;
            if (out_take)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:   if (s_tvalid) state_reg <= S_TA_GO;
                S_TA_GO:  state_reg <= S_TA_W;
                S_TA_W:   if (cor_done) state_reg <= S_TAD_GO;
                S_TAD_GO: state_reg <= S_TAD_W;
                S_TAD_W:  if (div_done) state_reg <= S_TB_GO;
                S_TB_GO:  state_reg <= S_TB_W;
                S_TB_W:   if (cor_done) state_reg <= S_TBD_GO;
                S_TBD_GO: state_reg <= S_TBD_W;
                S_TBD_W:  if (div_done) state_reg <= S_DIF;
                S_DIF:    state_reg <= (dtan == '0) ? S_MOT : S_P_GO;
                S_P_GO:   state_reg <= S_P_W;
                S_P_W:    if (mul_done) state_reg <= S_Q_GO;
                S_Q_GO:   state_reg <= S_Q_W;
                S_Q_W:    if (div_done) state_reg <= (ta_reg == '0) ? S_SAT : S_QT_GO;
                S_QT_GO:  state_reg <= S_QT_W;
                S_QT_W:
                begin
                    if (mul_done)
                        state_reg <= (mul_p > 96'hFFFF_FFFF_0000_0000) ? S_SAT : S_RT_GO;
                end
                S_RT_GO:  state_reg <= S_RT_W;
                S_RT_W:   if (mul_done) state_reg <= S_RTD_GO;
                S_RTD_GO: state_reg <= S_RTD_W;
                S_RTD_W:  if (div_done) state_reg <= S_SAT;
                S_SAT:    state_reg <= S_MOT;
                S_MOT:    state_reg <= have_last_reg ? S_SX_GO : S_OUT;
                S_SX_GO:  state_reg <= S_SX_W;
                S_SX_W:   if (mul_done) state_reg <= S_SY_GO;
                S_SY_GO:  state_reg <= S_SY_W;
                S_SY_W:   if (mul_done) state_reg <= ssum[64] ? S_HD : S_SQ_GO;
                S_SQ_GO:  state_reg <= S_SQ_W;
                S_SQ_W:   if (sq_done) state_reg <= S_HD;
                S_HD:
                begin
                    if (dx_reg == '0)
                        state_reg <= S_OUT;     // vertical or no motion, fixed heading
                    else
                        state_reg <= S_HV_GO;
                end
                S_HV_GO:  state_reg <= S_HV_W;
                S_HV_W:   if (cor_done) state_reg <= S_HM_GO;
                S_HM_GO:  state_reg <= S_HM_W;
                S_HM_W:   if (mul_done) state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_take)
                    begin
                        have_last_reg <= 1'b1;
                        last_x_reg    <= px_reg;
                        last_y_reg    <= py_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                an_reg  <= (s_tdata[14:0] > ttt_pkg::ANGLE_MAX) ? ttt_pkg::ANGLE_MAX
                                                                 : s_tdata[14:0];
                af_reg  <= (s_tdata[29:15] > ttt_pkg::ANGLE_MAX) ? ttt_pkg::ANGLE_MAX
                                                                  : s_tdata[29:15];
                err_reg <= 1'b0;
                spd_reg <= '0;
                hd_reg  <= '0;
            end
            S_TAD_W:
            begin
                if (div_done)
                begin
                    if (div_q > ttt_pkg::DIV_NW'(32'hFFFF_FFFF))
                    begin
                        ta_reg  <= '1;
                        err_reg <= 1'b1;
                    end
                    else
                        ta_reg <= div_q[31:0];
                end
            end
            S_TBD_W:
            begin
                if (div_done)
                begin
                    if (div_q > ttt_pkg::DIV_NW'(32'hFFFF_FFFF))
                    begin
                        tb_reg  <= '1;
                        err_reg <= 1'b1;
                    end
                    else
                        tb_reg <= div_q[31:0];
                end
            end
            S_DIF:
            begin
                neg_reg <= dtan[32];
                ad_reg  <= dtan[32] ? 32'(-dtan) : dtan[31:0];
                if (dtan == '0)
                begin
                    px_reg  <= 32'sh7FFF_FFFF;
                    py_reg  <= 32'sh7FFF_FFFF;
                    err_reg <= 1'b1;
                end
            end
            S_P_W:    if (mul_done) p_reg <= mul_p[55:0];
            S_Q_W:
            begin
                if (div_done)
                begin
                    q_reg  <= div_q[55:0];
                    r_reg  <= div_r[31:0];
                    my_reg <= '0;
                end
            end
            S_QT_W:
            begin
                if (mul_done)
                begin
                    qt_reg <= mul_p[63:0];
                    my_reg <= '1;
                end
            end
            S_RT_W:   if (mul_done) rt_reg <= mul_p[63:0];
            S_RTD_W:  if (div_done) my_reg <= (qt_reg + div_q[63:0]) >> ttt_pkg::FRAC_BITS;
            S_SAT:
            begin
                px_reg  <= signed'(sat_x[31:0]);
                py_reg  <= signed'(sat_y[31:0]);
                err_reg <= err_reg | sat_x[32] | sat_y[32];
            end
            S_MOT:
            begin
                dx_reg <= 33'(px_reg) - 33'(last_x_reg);
                dy_reg <= 33'(py_reg) - 33'(last_y_reg);
            end
            S_SX_W:   if (mul_done) sx_reg <= mul_p[63:0];
            S_SY_W:
            begin
                if (mul_done)
                begin
                    sq_reg <= ssum[63:0];
                    if (ssum[64])
                    begin
                        spd_reg <= '1;
                        err_reg <= 1'b1;
                    end
                end
            end
            S_SQ_W:   if (sq_done) spd_reg <= sq_root;
            S_HD:
            begin
                if (dx_reg == '0)
                begin
                    if (dy_reg == '0)
                        hd_reg <= '0;
                    else if (dy_reg[32])
                        hd_reg <= -signed'(ttt_pkg::HEADING_MAX);
                    else
                        hd_reg <= signed'(ttt_pkg::HEADING_MAX);
                end
            end
            S_HV_W:   if (cor_done) hz_reg <= cor_z[ttt_pkg::ZW-1] ? '0 : cor_z;
            S_HM_W:
            begin
                // sign from the quadrant of the displacement
                if (mul_done)
                    hd_reg <= (dx_reg[32] != dy_reg[32]) ? -signed'(hmag) : signed'(hmag);
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    out_data_reg <= {hd_reg, spd_reg, py_reg, px_reg};
                    out_user_reg <= {err_reg, have_last_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: dv/ttt_checker.sv
// Checker for the triangulation tracker: watches the input, result and baseline channels,
// predicts each result word, compares it, shows a mismatch by field. Depends on ttt_pkg.
`timescale 1ns / 100ps
module ttt_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [31:0]    s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [111:0]   m_tdata,
    input  logic [1:0]     m_tuser,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [23:0]    cfg_data,
    output int             fail_count,
    output int             pending,
    output int             result_count,
    output int             error_count
);

    localparam longint     ONE_Q30   = 64'd1 << 30;
    localparam bit [63:0]  MAX64     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint     HEAD_LIM  = 23040;
    localparam bit [14:0]  ANG_LIM   = 15'd23039;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] speed;
        logic [15:0] heading;
        logic        motion_valid;
        logic        geometry_error;
    } fix_t;

    fix_t      fix_q[$];
    bit [23:0] baseline;
    longint    prev_x;
    longint    prev_y;
    bit        have_prev;

    // atan(2^-i), Q30 radians
    function automatic longint rot_angle(input int i);
        longint head [10];
        head = '{843314857, 497837829, 263043837, 133525159, 67021687,
                 33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return head[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic bit [63:0] tan_q(input bit [14:0] ang, inout bit err);
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        bit [63:0] t;
        x = ONE_Q30;
        y = 0;
        z = longint'(((64'(ang) * 64'd4685083) + 64'd32) >> 6);
        for (int i = 0; i < ttt_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= rot_angle(i);
            end
            else
            begin
                x += ys; y -= xs; z += rot_angle(i);
            end
        end
        if (x < 1)
            x = 1;
        if (y < 0)
            y = 0;
        t = ((64'(y) << ttt_pkg::FRAC_BITS) + (64'(x) >> 1)) / 64'(x);
        if (t > 64'hFFFF_FFFF)
        begin
            t = 64'hFFFF_FFFF;
            err = 1'b1;
        end
        return t;
    endfunction

    function automatic longint clip32(input bit [63:0] mag, input bit neg, inout bit err);
        if (!neg)
        begin
            if (mag > 64'h7FFF_FFFF)
            begin
                err = 1'b1;
                return 64'h7FFF_FFFF;
            end
            return longint'(mag);
        end
        if (mag > 64'h8000_0000)
        begin
            err = 1'b1;
            mag = 64'h8000_0000;
        end
        return -longint'(mag);
    endfunction

    function automatic bit [63:0] root_floor(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint incline(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint h;
        bit     neg;
        if (dx == 0 && dy == 0)
            return 0;
        if (dx == 0)
            return (dy > 0) ? HEAD_LIM : -HEAD_LIM;
        neg = (dx < 0) != (dy < 0);
        x = (dx < 0) ? -dx : dx;
        y = (dy < 0) ? -dy : dy;
        z = 0;
        for (int i = 0; i < ttt_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += rot_angle(i);
            end
            else
            begin
                x -= ys; y += xs; z -= rot_angle(i);
            end
        end
        if (z < 0)
            z = 0;
        h = longint'((64'(z) * 64'd15019745 + (64'd1 << 39)) >> 40);
        if (h > HEAD_LIM)
            h = HEAD_LIM;
        return neg ? -h : h;
    endfunction

    // one sighting in, one fix out; updates the stored position
    function automatic fix_t locate(input bit [14:0] a_near, input bit [14:0] a_far);
        fix_t      f;
        bit        err;
        bit [63:0] ta;
        bit [63:0] tb;
        bit [63:0] ad;
        bit [63:0] p;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] my;
        bit [63:0] ux;
        bit [63:0] uy;
        bit [63:0] spd;
        longint    d;
        longint    px;
        longint    py;
        longint    dx;
        longint    dy;
        longint    hd;
        err = 1'b0;
        spd = 0;
        hd = 0;
        if (a_near > ANG_LIM)
            a_near = ANG_LIM;
        if (a_far > ANG_LIM)
            a_far = ANG_LIM;
        ta = tan_q(a_near, err);
        tb = tan_q(a_far, err);
        d = longint'(tb) - longint'(ta);
        if (d == 0)
        begin
            px = 64'h7FFF_FFFF;
            py = 64'h7FFF_FFFF;
            err = 1'b1;
        end
        else
        begin
            ad = (d < 0) ? 64'(-d) : 64'(d);
            p = 64'(baseline) * tb;
            q = p / ad;
            r = p % ad;
            if (ta == 0)
                my = 0;
            else if (q > (MAX64 - 64'hFFFF_FFFF) / ta)
                my = MAX64;
            else
                my = (q * ta + (r * ta) / ad) >> ttt_pkg::FRAC_BITS;
            px = clip32(q, d < 0, err);
            py = clip32(my, d < 0, err);
        end
        if (have_prev)
        begin
            dx = px - prev_x;
            dy = py - prev_y;
            ux = (dx < 0) ? 64'(-dx) : 64'(dx);
            uy = (dy < 0) ? 64'(-dy) : 64'(dy);
            if (ux * ux > MAX64 - uy * uy)
            begin
                spd = 64'hFFFF_FFFF;
                err = 1'b1;
            end
            else
                spd = root_floor(ux * ux + uy * uy);
            hd = incline(dx, dy);
        end
        f.pos_x          = px[31:0];
        f.pos_y          = py[31:0];
        f.speed          = spd[31:0];
        f.heading        = hd[15:0];
        f.motion_valid   = have_prev;
        f.geometry_error = err;
        prev_x = px;
        prev_y = py;
        have_prev = 1'b1;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fix_t exp_f;
        fix_t got_f;
        if (!rst_n)
        begin
            baseline     <= ttt_pkg::BASE_RESET;
            prev_x       = 0;
            prev_y       = 0;
            have_prev    = 1'b0;
            fail_count   <= 0;
            result_count <= 0;
            error_count  <= 0;
            pending      <= 0;
            fix_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                baseline <= cfg_data;
            if (s_tvalid && s_tready)
                fix_q.push_back(locate(s_tdata[14:0], s_tdata[29:15]));
            if (m_tvalid && m_tready)
            begin
                // tdata carries pos_x in the low bits, the struct wants it on top
                got_f = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[111:96],
                         m_tuser[0], m_tuser[1]};
                result_count <= result_count + 1;
                if (m_tuser[1])
                    error_count <= error_count + 1;
                if (fix_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result word %h", $realtime, got_f);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_f = fix_q.pop_front();
                    if (got_f !== exp_f)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch x %h/%h y %h/%h spd %h/%h",
                                     $realtime, exp_f.pos_x, got_f.pos_x,
                                     exp_f.pos_y, got_f.pos_y, exp_f.speed, got_f.speed);
                            $display("    hdg %h/%h mv %b/%b err %b/%b",
                                     exp_f.heading, got_f.heading,
                                     exp_f.motion_valid, got_f.motion_valid,
                                     exp_f.geometry_error, got_f.geometry_error);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= fix_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Top of the tracker testbench: clock, reset, sighting and baseline stimulus, result back-pressure.
// Depends on ttt_pkg, the tracker RTL and ttt_checker, which predicts and compares.
`timescale 1ns / 100ps
module tb_top;

    localparam int QUIET_LIMIT = 20000;  // cycles with no word moving
    localparam int DRAIN_WAIT  = 500;    // drain margin after the last word
    localparam int HOLD_CYCLES = 2000;   // long receiver hold, so the block backs up

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [31:0]    s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [111:0]   m_tdata;
    logic [1:0]     m_tuser;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [23:0]    cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int sightings;
    bit hold_done;

    two_angle_triangulation_tracker u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ttt_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .error_count  (error_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // offer one sighting word, with random idle cycles ahead of it;
    // tvalid stays high on return so back-to-back words never drop it
    task automatic offer_sighting(input logic [14:0] a_near, input logic [14:0] a_far);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, a_far, a_near};
        do
            @(posedge clk);
        while (!s_tready);
        sightings++;
    endtask

    // wait until the block is idle, then load a new baseline
    task automatic load_baseline(input logic [23:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly legal angles; now and then out of range to hit the clamp and the top bits
    function automatic logic [14:0] pick_angle();
        case ($urandom_range(19))
            0:       return 15'($urandom_range(32767, 23040));
            1:       return 15'($urandom_range(3));
            2:       return 15'($urandom_range(23039, 22900));
            default: return 15'($urandom_range(23039));
        endcase
    endfunction

    // one run of random words under the current baseline and idle mix
    task automatic sweep(input int count);
        logic [14:0] a_near;
        logic [14:0] a_far;
        for (int k = 0; k < count; k++)
        begin
            a_near = pick_angle();
            a_far  = ($urandom_range(15) == 0) ? a_near : pick_angle();
            // a repeated fix now and then: zero motion
            if ($urandom_range(31) == 0)
            begin
                offer_sighting(a_near, a_far);
            end
            offer_sighting(a_near, a_far);
        end
    endtask

    // receiver: random stalls by phase, plus one long hold while words keep coming
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && result_count >= 100)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: no word on any channel for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: %0d quiet cycles, %0d words outstanding", quiet_cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        sightings = 0;
        send_idle_pct = 11;
        recv_idle_pct = 78;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset baseline, angle extremes, equal tangents, clamp, no motion
        offer_sighting(15'd0, 15'd0);
        offer_sighting(15'd0, 15'd23039);
        offer_sighting(15'd23039, 15'd0);
        offer_sighting(15'd23039, 15'd23039);
        offer_sighting(15'd32767, 15'd100);
        offer_sighting(15'd5000, 15'd10000);
        offer_sighting(15'd10000, 15'd5000);
        offer_sighting(15'd10000, 15'd5000);
        offer_sighting(15'd1, 15'd2);
        offer_sighting(15'd16384, 15'd21845);
        offer_sighting(15'd0, 15'd32767);
        load_baseline(24'hFFFFFF);
        offer_sighting(15'd23000, 15'd22990);
        offer_sighting(15'd256, 15'd23039);
        offer_sighting(15'd23039, 15'd256);
        offer_sighting(15'd11520, 15'd11521);
        load_baseline(24'd0);
        offer_sighting(15'd3000, 15'd9000);
        offer_sighting(15'd0, 15'd0);
        load_baseline(24'd1);
        offer_sighting(15'd7000, 15'd20000);
        offer_sighting(15'd20000, 15'd7000);

        // random, sender light / receiver heavy
        load_baseline(24'd128000);
        sweep(400);
        // one pause with nothing outstanding
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        sweep(150);

        // sender heavy / receiver light
        send_idle_pct = 78;
        recv_idle_pct = 11;
        load_baseline(24'($urandom_range(24'hFFFFFF)));
        sweep(300);
        load_baseline(24'hFFFFFF);
        sweep(100);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_baseline(24'($urandom_range(2000)));
        sweep(250);
        load_baseline(24'($urandom_range(24'hFFFFFF)));
        sweep(500);
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d sightings, %0d fixes (%0d flagged), eight baseline loads",
                 sightings, result_count, error_count);
        $display("baselines incl. 0 and max; stall mixes 11/78, 78/11 and none, one long hold");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
src/ttt_pkg.sv
src/ttt_cordic.sv
src/ttt_div.sv
src/ttt_mul.sv
src/ttt_sqrt.sv
src/two_angle_triangulation_tracker.sv
dv/ttt_checker.sv
dv/tb_top.sv
